// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/e2q_pkg.sv -----
// Package for the Euler-to-quaternion converter: CORDIC constants and types.
// No dependencies.
`default_nettype none
package e2q_pkg;
  localparam int CordicSteps = 20;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;
  typedef logic signed [31:0] cword_t;
  typedef logic signed [17:0] trig_t;

  function automatic cword_t atan_entry(input logic [4:0] i);
    cword_t r;
    r = '0;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/e2q_cordic.sv -----
// Pipelined CORDIC: cos and sin of half a binary angle, Q16, one stage per step.
// Depends on e2q_pkg.
`default_nettype none
module e2q_cordic (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [15:0] angle,
  output e2q_pkg::trig_t cos_out,
  output e2q_pkg::trig_t sin_out
);
  import e2q_pkg::*;
  cword_t x [CordicSteps+1];
  cword_t y [CordicSteps+1];
  cword_t z [CordicSteps+1];
  logic signed [32:0] xr;
  logic signed [32:0] yr;

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= CordicGain;
      y[0] <= '0;
      z[0] <= $signed({angle, 16'd0}) >>> 1;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][31]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_entry(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_entry(5'(i));
        end
      end
    end
  end

  assign xr = 33'(x[CordicSteps]) + 33'sd8192;
  assign yr = 33'(y[CordicSteps]) + 33'sd8192;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= xr[31:14];
      sin_out <= yr[31:14];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/e2q_combine.sv -----
// Triple products, sums, rounding and saturation to Q1.15, each registered.
// Depends on e2q_pkg.
`default_nettype none
module e2q_combine (
  input  wire logic clk,
  input  wire logic en,
  input  e2q_pkg::trig_t cr, sr, cp, sp, cy, sy,
  output logic signed [15:0] qx, qy, qz, qw
);
  import e2q_pkg::*;
  logic signed [33:0] crcp, srsp, srcp, crsp;
  trig_t cy1, sy1;
  logic signed [50:0] p [8];
  logic signed [51:0] sw, sx, sy_s, sz;

  function automatic logic signed [15:0] to_q15(input logic signed [51:0] v);
    logic signed [51:0] t;
    logic signed [18:0] r;
    t = v + 52'sh100000000;
    r = t[51:33];
    if (r > 19'sd32767) return 16'sh7fff;
    if (r < -19'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      crcp <= cr * cp; srsp <= sr * sp; srcp <= sr * cp; crsp <= cr * sp;
      cy1 <= cy; sy1 <= sy;
      p[0] <= crcp * cy1; p[1] <= srsp * sy1;
      p[2] <= srcp * cy1; p[3] <= crsp * sy1;
      p[4] <= crsp * cy1; p[5] <= srcp * sy1;
      p[6] <= crcp * sy1; p[7] <= srsp * cy1;
      sw <= 52'(p[0]) + 52'(p[1]);
      sx <= 52'(p[2]) - 52'(p[3]);
      sy_s <= 52'(p[4]) + 52'(p[5]);
      sz <= 52'(p[6]) - 52'(p[7]);
      qw <= to_q15(sw); qx <= to_q15(sx); qy <= to_q15(sy_s); qz <= to_q15(sz);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/euler_to_quaternion_top.sv -----
// Euler angles (ZYX) to Q1.15 quaternion, streaming top level.
// Depends on e2q_pkg, e2q_cordic, e2q_combine, assert_macros.svh.
// channel  dir  payload
// s_axis   in   roll, pitch, yaw (16b each)
// m_axis   out  x, y, z, w (16b each)
// Pipeline: 22 CORDIC stages, 4 combine stages; one beat per cycle while the output is not stalled.
// Reset clears the valid bits only. A stall freezes the whole pipeline.
// Input ready drops only while a finished beat waits at the output.
`default_nettype none
`include "assert_macros.svh"
module euler_to_quaternion_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [47:0] s_axis_tdata, // roll_angle, pitch_angle, yaw_angle
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [63:0] m_axis_tdata      // quat_x, quat_y, quat_z, quat_w
);
  import e2q_pkg::*;
  localparam int Lat = CordicSteps + 6;
  logic [Lat-1:0] vld;
  logic en;
  trig_t cr, sr, cp, sp, cy, sy;
  logic signed [15:0] qx, qy, qz, qw;

  assign en = m_axis_tready || !vld[Lat-1];
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Lat-1];
  assign m_axis_tdata = {qw, qz, qy, qx};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_axis_tvalid};
    end
  end

  e2q_cordic u_roll (.clk, .en, .angle(s_axis_tdata[15:0]), .cos_out(cr), .sin_out(sr));
  e2q_cordic u_pitch (.clk, .en, .angle(s_axis_tdata[31:16]), .cos_out(cp), .sin_out(sp));
  e2q_cordic u_yaw (.clk, .en, .angle(s_axis_tdata[47:32]), .cos_out(cy), .sin_out(sy));
  e2q_combine u_comb (.clk, .en, .cr, .sr, .cp, .sp, .cy, .sy, .qx, .qy, .qz, .qw);

  `ASSERT_IMPL(a_ready, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
`default_nettype wire
